FILE: design/rers_pkg.sv
// Shared types, codes and arithmetic helpers for the recurrent event rate score block.
`timescale 1ns / 1ps
package rers_pkg;

	localparam int DEF_MAX_SUBJECTS   = 256;
	localparam int DEF_MAX_COVARIATES = 4;
	localparam int DEF_MAX_EVENTS     = 1024;

	localparam logic [1:0] OP_LOAD_SUBJ  = 2'd0;
	localparam logic [1:0] OP_LOAD_COV   = 2'd1;
	localparam logic [1:0] OP_LOAD_EVENT = 2'd2;
	localparam logic [1:0] OP_RUN        = 2'd3;

	localparam logic [2:0] CFG_COV_RESET = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ISTART,
		ST_ILATCH,
		ST_EREAD,
		ST_ECHECK,
		ST_ENEXT,
		ST_JREAD,
		ST_JCHK,
		ST_CREAD,
		ST_CMUL,
		ST_CACC,
		ST_JNEXT,
		ST_DREAD,
		ST_DXL,
		ST_DIV,
		ST_DIFF,
		ST_SMUL,
		ST_SACC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic accept;
		logic sub_rd_i;
		logic sub_rd_j;
		logic i_latch;
		logic i_next;
		logic ev_rd;
		logic ev_take;
		logic e_next;
		logic j_take;
		logic j_next;
		logic cov_rd_i;
		logic cov_rd_j;
		logic rmul;
		logic racc;
		logic r_next;
		logic r_clr;
		logic x_take;
		logic diff;
		logic smul;
		logic sacc;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic i_end;
		logic ev_none;
		logic e_last;
		logic ev_hit;
		logic j_hit;
		logic j_last;
		logic r_last;
		logic div_done;
	} stat_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		begin
			s = {a[63], a} + {b[63], b};
			if (s[64] != s[63]) begin
				sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			end else begin
				sat_add64 = s[63:0];
			end
		end
	endfunction

endpackage

FILE: design/recurrent_event_rate_score.sv
// Top level of the recurrent event rate score block.
//
// channel   direction  handshake                 payload
// command   in         start & !busy             op, subject, covariate, time_value,
//                                                subject_weight, covariate_value, subject_count
// config    in         cfg_valid & cfg_ready     cfg_data (covariates in use)
// result    out        result_valid, one cycle   score_index, score, last
//
// Loads leave busy low. A run is paced by its multiply steps, single-port stores and
// a bit-serial divider. Results leave one per cycle and cannot be stalled. Reset
// clears the event count and restores four covariates in use; stored subjects,
// covariates and events are undefined until loaded.
`timescale 1ns / 1ps
module recurrent_event_rate_score #(
	parameter int MAX_SUBJECTS   = rers_pkg::DEF_MAX_SUBJECTS,
	parameter int MAX_COVARIATES = rers_pkg::DEF_MAX_COVARIATES,
	parameter int MAX_EVENTS     = rers_pkg::DEF_MAX_EVENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         op,
	input  logic [7:0]         subject,
	input  logic [1:0]         covariate,
	input  logic [31:0]        time_value,
	input  logic [23:0]        subject_weight,
	input  logic signed [31:0] covariate_value,
	input  logic [8:0]         subject_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_data,
	output logic               result_valid,
	output logic [1:0]         score_index,
	output logic signed [63:0] score,
	output logic               last
);
	import rers_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	rers_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	rers_dp #(
		.MAX_SUBJECTS   (MAX_SUBJECTS),
		.MAX_COVARIATES (MAX_COVARIATES),
		.MAX_EVENTS     (MAX_EVENTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.op              (op),
		.subject         (subject),
		.covariate       (covariate),
		.time_value      (time_value),
		.subject_weight  (subject_weight),
		.covariate_value (covariate_value),
		.subject_count   (subject_count),
		.cfg_wr          (cfg_valid && cfg_ready),
		.cfg_data        (cfg_data),
		.result_valid    (result_valid),
		.score_index     (score_index),
		.score           (score),
		.last            (last)
	);
endmodule

FILE: design/rers_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`timescale 1ns / 1ps
module rers_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [31:0] den,
	output logic [63:0] quo,
	output logic        done
);
	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [32:0] rs;
	logic        ge;

	assign rs = {rem_q, quo_q[63]};
	assign ge = rs >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '1;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			quo_q <= {quo_q[62:0], ge};
			rem_q <= ge ? 32'(rs - {1'b0, den_q}) : rs[31:0];
		end
	end

	assign quo  = quo_q;
	assign done = done_q;
endmodule

FILE: design/rers_ctrl.sv
// Run sequencer: walks subjects, events, the risk set and the score update.
`timescale 1ns / 1ps
module rers_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     op,
	input  rers_pkg::stat_t stat,
	output rers_pkg::cmd_t  cmd,
	output logic           busy
);
	import rers_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (start && op == OP_RUN) state_d = ST_ISTART;
			ST_ISTART: begin
				if (stat.i_end) state_d = ST_EMIT;
				else if (!stat.ev_none) state_d = ST_ILATCH;
			end
			ST_ILATCH: state_d = ST_EREAD;
			ST_EREAD:  state_d = ST_ECHECK;
			ST_ECHECK: state_d = stat.ev_hit ? ST_JREAD : ST_ENEXT;
			ST_ENEXT:  state_d = stat.e_last ? ST_ISTART : ST_EREAD;
			ST_JREAD:  state_d = ST_JCHK;
			ST_JCHK:   state_d = stat.j_hit ? ST_CREAD : ST_JNEXT;
			ST_CREAD:  state_d = ST_CMUL;
			ST_CMUL:   state_d = ST_CACC;
			ST_CACC:   state_d = stat.r_last ? ST_JNEXT : ST_CREAD;
			ST_JNEXT:  state_d = stat.j_last ? ST_DREAD : ST_JREAD;
			ST_DREAD:  state_d = ST_DXL;
			ST_DXL:    state_d = ST_DIV;
			ST_DIV:    if (stat.div_done) state_d = ST_DIFF;
			ST_DIFF:   state_d = ST_SMUL;
			ST_SMUL:   state_d = ST_SACC;
			ST_SACC:   state_d = stat.r_last ? ST_ENEXT : ST_DREAD;
			ST_EMIT:   if (stat.r_last) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.accept = start;
			ST_ISTART: begin
				if (stat.i_end) cmd.r_clr = 1'b1;
				else if (stat.ev_none) cmd.i_next = 1'b1;
				else cmd.sub_rd_i = 1'b1;
			end
			ST_ILATCH: cmd.i_latch = 1'b1;
			ST_EREAD:  cmd.ev_rd = 1'b1;
			ST_ECHECK: cmd.ev_take = stat.ev_hit;
			ST_ENEXT: begin
				if (stat.e_last) cmd.i_next = 1'b1;
				else cmd.e_next = 1'b1;
			end
			ST_JREAD:  cmd.sub_rd_j = 1'b1;
			ST_JCHK:   cmd.j_take = stat.j_hit;
			ST_CREAD:  cmd.cov_rd_j = 1'b1;
			ST_CMUL:   cmd.rmul = 1'b1;
			ST_CACC: begin
				cmd.racc   = 1'b1;
				cmd.r_next = !stat.r_last;
			end
			ST_JNEXT: begin
				if (stat.j_last) cmd.r_clr = 1'b1;
				else cmd.j_next = 1'b1;
			end
			ST_DREAD:  cmd.cov_rd_i = 1'b1;
			ST_DXL:    cmd.x_take = 1'b1;
			ST_DIV:    cmd = '0;
			ST_DIFF:   cmd.diff = 1'b1;
			ST_SMUL:   cmd.smul = 1'b1;
			ST_SACC: begin
				cmd.sacc   = 1'b1;
				cmd.r_next = !stat.r_last;
			end
			ST_EMIT: begin
				cmd.emit   = 1'b1;
				cmd.r_next = !stat.r_last;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

FILE: design/rers_dp.sv
// Datapath: subject, covariate and event stores, counters, risk-set sums and score update.
`timescale 1ns / 1ps
module rers_dp #(
	parameter int MAX_SUBJECTS   = rers_pkg::DEF_MAX_SUBJECTS,
	parameter int MAX_COVARIATES = rers_pkg::DEF_MAX_COVARIATES,
	parameter int MAX_EVENTS     = rers_pkg::DEF_MAX_EVENTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rers_pkg::cmd_t      cmd,
	output rers_pkg::stat_t     stat,
	input  logic [1:0]          op,
	input  logic [7:0]          subject,
	input  logic [1:0]          covariate,
	input  logic [31:0]         time_value,
	input  logic [23:0]         subject_weight,
	input  logic signed [31:0]  covariate_value,
	input  logic [8:0]          subject_count,
	input  logic                cfg_wr,
	input  logic [2:0]          cfg_data,
	output logic                result_valid,
	output logic [1:0]          score_index,
	output logic signed [63:0]  score,
	output logic                last
);
	import rers_pkg::*;

	localparam int SW  = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
	localparam int NCW = $clog2(MAX_SUBJECTS + 1);
	localparam int CW  = (MAX_COVARIATES > 1) ? $clog2(MAX_COVARIATES) : 1;
	localparam int PW  = $clog2(MAX_COVARIATES + 1);
	localparam int EW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int ECW = $clog2(MAX_EVENTS + 1);
	localparam int CD  = MAX_SUBJECTS * MAX_COVARIATES;
	localparam int CAW = $clog2(CD);

	// stores: {follow-up, weight}, {owner, event time}, covariates
	logic [55:0]        sub_mem [MAX_SUBJECTS];
	logic [39:0]        ev_mem  [MAX_EVENTS];
	logic signed [31:0] cov_mem [CD];
	logic [55:0]        sub_rd_q;
	logic [39:0]        ev_rd_q;
	logic signed [31:0] cov_rd_q;

	logic [NCW-1:0] n_q, i_q, j_q;
	logic [ECW-1:0] ec_q, e_q;
	logic [CW-1:0]  r_q;
	logic [2:0]     cfg_q;
	logic [PW-1:0]  p_eff;

	logic [31:0]        fu_i_q, t_q, wsum_q;
	logic [23:0]        w_i_q, wj_q;
	logic signed [56:0] prod_q;
	logic signed [31:0] x_q;
	logic signed [32:0] diff_q;
	logic signed [57:0] term_q;
	logic               neg_q;
	logic signed [63:0] risk_q  [MAX_COVARIATES];
	logic signed [63:0] score_q [MAX_COVARIATES];

	logic               ld_sub, ld_cov, ld_ev, run_go;
	logic [SW-1:0]      sub_addr;
	logic [NCW-1:0]     cov_base;
	logic [CAW-1:0]     cov_rd_addr, cov_wr_addr;
	logic [32:0]        wsum_add;
	logic signed [63:0] risk_r;
	logic [63:0]        mag;
	logic [63:0]        quo;
	logic               div_done;
	logic signed [33:0] mean;
	logic signed [33:0] diff_full;

	assign ld_sub = cmd.accept && op == OP_LOAD_SUBJ && 32'(subject) < MAX_SUBJECTS;
	assign ld_cov = cmd.accept && op == OP_LOAD_COV && 32'(subject) < MAX_SUBJECTS
		&& 32'(covariate) < MAX_COVARIATES;
	assign ld_ev  = cmd.accept && op == OP_LOAD_EVENT && 32'(ec_q) < MAX_EVENTS;
	assign run_go = cmd.accept && op == OP_RUN;

	assign sub_addr    = cmd.sub_rd_i ? i_q[SW-1:0] : j_q[SW-1:0];
	assign cov_base    = cmd.cov_rd_i ? i_q : j_q;
	assign cov_rd_addr = CAW'(32'(cov_base) * MAX_COVARIATES + 32'(r_q));
	assign cov_wr_addr = CAW'(32'(subject) * MAX_COVARIATES + 32'(covariate));

	always_ff @(posedge clk) begin
		if (ld_sub) sub_mem[SW'(subject)] <= {time_value, subject_weight};
		if (cmd.sub_rd_i || cmd.sub_rd_j) sub_rd_q <= sub_mem[sub_addr];
	end

	always_ff @(posedge clk) begin
		if (ld_ev) ev_mem[ec_q[EW-1:0]] <= {subject, time_value};
		if (cmd.ev_rd) ev_rd_q <= ev_mem[e_q[EW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ld_cov) cov_mem[cov_wr_addr] <= covariate_value;
		if (cmd.cov_rd_i || cmd.cov_rd_j) cov_rd_q <= cov_mem[cov_rd_addr];
	end

	always_comb begin
		if (cfg_q == 3'd0) p_eff = PW'(1);
		else if (32'(cfg_q) > MAX_COVARIATES) p_eff = PW'(MAX_COVARIATES);
		else p_eff = PW'(cfg_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			i_q    <= '0;
			j_q    <= '0;
			e_q    <= '0;
			r_q    <= '0;
			ec_q   <= '0;
			cfg_q  <= CFG_COV_RESET;
			result_valid <= 1'b0;
		end else begin
			if (cfg_wr) cfg_q <= cfg_data;
			if (ld_ev) ec_q <= ec_q + ECW'(1);
			if (run_go) begin
				n_q <= (32'(subject_count) > MAX_SUBJECTS) ? NCW'(MAX_SUBJECTS)
					: NCW'(subject_count);
				i_q <= '0;
			end
			if (cmd.i_next) i_q <= i_q + NCW'(1);
			if (cmd.i_latch) e_q <= '0;
			if (cmd.e_next) e_q <= e_q + ECW'(1);
			if (cmd.ev_take) j_q <= '0;
			if (cmd.j_next) j_q <= j_q + NCW'(1);
			if (cmd.j_take || cmd.r_clr) r_q <= '0;
			else if (cmd.r_next) r_q <= r_q + CW'(1);
			result_valid <= cmd.emit;
		end
	end

	assign wsum_add  = {1'b0, wsum_q} + 33'(sub_rd_q[23:0]);
	assign risk_r    = risk_q[r_q];
	assign mag       = risk_r[63] ? 64'(-risk_r) : 64'(risk_r);

	always_comb begin
		if (neg_q) begin
			mean = (quo > 64'h8000_0000) ? -34'sh8000_0000 : -$signed({1'b0, quo[32:0]});
		end else begin
			mean = (quo > 64'h7FFF_FFFF) ? 34'sh7FFF_FFFF : $signed({1'b0, quo[32:0]});
		end
		diff_full = (wsum_q == 32'd0) ? 34'(x_q) : 34'(x_q) - mean;
	end

	rers_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.x_take),
		.num    (mag),
		.den    (wsum_q),
		.quo    (quo),
		.done   (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.i_latch) begin
			fu_i_q <= sub_rd_q[55:24];
			w_i_q  <= sub_rd_q[23:0];
		end
		if (cmd.ev_take) begin
			t_q    <= ev_rd_q[31:0];
			wsum_q <= '0;
			for (int k = 0; k < MAX_COVARIATES; k++) risk_q[k] <= '0;
		end
		if (cmd.j_take) begin
			wsum_q <= wsum_add[32] ? 32'hFFFF_FFFF : wsum_add[31:0];
			wj_q   <= sub_rd_q[23:0];
		end
		if (cmd.rmul) prod_q <= $signed({1'b0, wj_q}) * cov_rd_q;
		if (cmd.racc) risk_q[r_q] <= sat_add64(risk_r, 64'(prod_q));
		if (cmd.x_take) begin
			x_q   <= cov_rd_q;
			neg_q <= risk_r[63];
		end
		if (cmd.diff) diff_q <= 33'(diff_full);
		if (cmd.smul) term_q <= $signed({1'b0, w_i_q}) * diff_q;
		if (run_go) begin
			for (int k = 0; k < MAX_COVARIATES; k++) score_q[k] <= '0;
		end
		if (cmd.sacc) score_q[r_q] <= sat_add64(score_q[r_q], 64'(term_q));
		if (cmd.emit) begin
			score_index <= 2'(r_q);
			score       <= score_q[r_q];
			last        <= stat.r_last;
		end
	end

	always_comb begin
		stat.i_end    = (i_q == n_q);
		stat.ev_none  = (ec_q == '0);
		stat.e_last   = (32'(e_q) + 32'd1 == 32'(ec_q));
		stat.ev_hit   = (32'(ev_rd_q[39:32]) == 32'(i_q)) && (ev_rd_q[31:0] <= fu_i_q);
		stat.j_hit    = (t_q <= sub_rd_q[55:24]);
		stat.j_last   = (32'(j_q) + 32'd1 == 32'(n_q));
		stat.r_last   = (32'(r_q) + 32'd1 == 32'(p_eff));
		stat.div_done = div_done;
	end
endmodule
